@@ rtl/core/dtdiff_pkg.sv @@
// Shared widths, constants and calendar tables for the date difference block.
`timescale 1ns / 1ps

package dtdiff_pkg;

  // Field widths
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int ORD_W   = 22;
  localparam int MSTART_W = 9;

  // Calendar limits
  localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;
  localparam logic [YEAR_W-1:0] YEAR_MIN = 14'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;

  // Divide-by-25 by reciprocal: floor(x / 25) == (x * 1311) >> 15 for x < 4681
  localparam int          DIV25_SHIFT = 15;
  localparam logic [10:0] DIV25_MUL   = 11'd1311;

  localparam logic [ORD_W-1:0] DAYS_PER_YEAR = 22'd365;

  // Days before the first of each month in a common year
  function automatic logic [MSTART_W-1:0] month_start(input logic [MONTH_W-1:0] m);
    logic [MSTART_W-1:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Month length; zero for a month code outside 1..12
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic lp);
    logic [DAY_W-1:0] r;
    case (m) inside
      4'd4, 4'd6, 4'd9, 4'd11:                   r = 5'd30;
      4'd2:                                      r = lp ? 5'd29 : 5'd28;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      default:                                   r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/date_difference_days_core.sv @@
// Top level: Gregorian date difference in days, one request per unstalled cycle.
`timescale 1ns / 1ps

// Takes a start and an end date (year, month, day) and returns the number of
// days from start to end under the Gregorian leap-year rule. date_error is set,
// with day_count zero, when either date is invalid (year outside 1..9999, month
// outside 1..12, day zero or past the month's end) or the start follows the end.
// A request is taken every cycle when the result side keeps up; there are two
// register stages, the input register and the result register, with the
// date-to-ordinal conversion and the subtract between them. in_ready follows
// out_ready combinationally when both stages are full.
module date_difference_days_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [dtdiff_pkg::YEAR_W-1:0]  in_start_year,
  input  logic [dtdiff_pkg::MONTH_W-1:0] in_start_month,
  input  logic [dtdiff_pkg::DAY_W-1:0]   in_start_day,
  input  logic [dtdiff_pkg::YEAR_W-1:0]  in_end_year,
  input  logic [dtdiff_pkg::MONTH_W-1:0] in_end_month,
  input  logic [dtdiff_pkg::DAY_W-1:0]   in_end_day,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [dtdiff_pkg::ORD_W-1:0]   out_day_count,
  output logic                           out_date_error
);

  logic                           s1_valid_r;
  logic [dtdiff_pkg::YEAR_W-1:0]  s_year_r,  e_year_r;
  logic [dtdiff_pkg::MONTH_W-1:0] s_month_r, e_month_r;
  logic [dtdiff_pkg::DAY_W-1:0]   s_day_r,   e_day_r;
  logic                           out_valid_r;
  logic [dtdiff_pkg::ORD_W-1:0]   day_count_r, day_count_nxt;
  logic                           date_error_r, date_error_nxt;
  logic [dtdiff_pkg::ORD_W-1:0]   ord_s, ord_e;
  logic                           ok_s, ok_e;
  logic                           adv;
  logic                           in_take;

  // Handshake: stage 2 moves when the result slot is free or being drained
  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;
  assign in_take  = in_valid && in_ready;

  // Ordinal conversion for both dates
  dtdiff_ordinal u_ord_start (
    .year  (s_year_r),
    .month (s_month_r),
    .day   (s_day_r),
    .ord   (ord_s),
    .ok    (ok_s)
  );

  dtdiff_ordinal u_ord_end (
    .year  (e_year_r),
    .month (e_month_r),
    .day   (e_day_r),
    .ord   (ord_e),
    .ok    (ok_e)
  );

  // Difference and error
  always_comb begin
    if (ok_s && ok_e && (ord_s <= ord_e)) begin
      day_count_nxt  = ord_e - ord_s;
      date_error_nxt = 1'b0;
    end else begin
      day_count_nxt  = '0;
      date_error_nxt = 1'b1;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (in_take) begin
      s_year_r  <= in_start_year;
      s_month_r <= in_start_month;
      s_day_r   <= in_start_day;
      e_year_r  <= in_end_year;
      e_month_r <= in_end_month;
      e_day_r   <= in_end_day;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (adv) begin
      day_count_r  <= day_count_nxt;
      date_error_r <= date_error_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_day_count  = day_count_r;
  assign out_date_error = date_error_r;

endmodule

@@ rtl/core/dtdiff_ordinal.sv @@
// Date to day ordinal conversion with validity check.
`timescale 1ns / 1ps

module dtdiff_ordinal (
  input  logic [dtdiff_pkg::YEAR_W-1:0]  year,
  input  logic [dtdiff_pkg::MONTH_W-1:0] month,
  input  logic [dtdiff_pkg::DAY_W-1:0]   day,
  output logic [dtdiff_pkg::ORD_W-1:0]   ord,
  output logic                           ok
);

  logic [dtdiff_pkg::YEAR_W-1:0]   p;
  logic [dtdiff_pkg::YEAR_W-3:0]   p_q4;
  logic [22:0]                     p_prod;
  logic [7:0]                      p_q100;
  logic [5:0]                      p_q400;
  logic [dtdiff_pkg::YEAR_W-3:0]   y_q4;
  logic [22:0]                     y_prod;
  logic [7:0]                      y_q100;
  logic                            y_div100;
  logic                            lp;
  logic                            year_ok;
  logic                            month_ok;
  logic                            day_ok;
  logic                            leap_adj;

  // Leap year: y % 400 == 0 is y % 100 == 0 together with y % 16 == 0
  always_comb begin
    y_q4     = year[dtdiff_pkg::YEAR_W-1:2];
    y_prod   = 23'(y_q4) * 23'(dtdiff_pkg::DIV25_MUL);
    y_q100   = y_prod[22:dtdiff_pkg::DIV25_SHIFT];
    y_div100 = ({1'b0, year} == 15'(y_q100) * 15'd100);
    lp       = (year[1:0] == 2'b00) && (!y_div100 || (year[3:0] == 4'b0000));
  end

  // Range checks
  always_comb begin
    year_ok  = (year >= dtdiff_pkg::YEAR_MIN) && (year <= dtdiff_pkg::YEAR_MAX);
    month_ok = (dtdiff_pkg::month_len(month, 1'b0) != 5'd0);
    day_ok   = (day != 5'd0) && (day <= dtdiff_pkg::month_len(month, lp));
    ok       = year_ok && month_ok && day_ok;
  end

  // Ordinal: 365*p + p/4 - p/100 + p/400 + days before month + leap_adj + day
  always_comb begin
    p        = year - dtdiff_pkg::YEAR_MIN;
    p_q4     = p[dtdiff_pkg::YEAR_W-1:2];
    p_prod   = 23'(p_q4) * 23'(dtdiff_pkg::DIV25_MUL);
    p_q100   = p_prod[22:dtdiff_pkg::DIV25_SHIFT];
    p_q400   = p_q100[7:2];
    leap_adj = lp && (month > dtdiff_pkg::MONTH_FEB);
    ord      = 22'(p) * dtdiff_pkg::DAYS_PER_YEAR
             + 22'(p_q4) - 22'(p_q100) + 22'(p_q400)
             + 22'(dtdiff_pkg::month_start(month))
             + 22'(leap_adj) + 22'(day);
  end

endmodule

@@ dv/day_count_checker.sv @@
// Channel monitor for the date difference block: predicts day counts and compares results.
`timescale 1ns / 1ps

module day_count_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [dtdiff_pkg::YEAR_W-1:0]  in_start_year,
  input  logic [dtdiff_pkg::MONTH_W-1:0] in_start_month,
  input  logic [dtdiff_pkg::DAY_W-1:0]   in_start_day,
  input  logic [dtdiff_pkg::YEAR_W-1:0]  in_end_year,
  input  logic [dtdiff_pkg::MONTH_W-1:0] in_end_month,
  input  logic [dtdiff_pkg::DAY_W-1:0]   in_end_day,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [dtdiff_pkg::ORD_W-1:0]   out_day_count,
  input  logic                           out_date_error,
  output int                             mismatches,
  output int                             pending
);

  typedef struct packed {
    logic [dtdiff_pkg::ORD_W-1:0] day_count;
    logic                         date_error;
  } date_span_t;

  date_span_t expected_spans[$];
  int         mismatch_total = 0;

  // Month length under the given leap flag; zero for a bad month
  function automatic int unsigned month_days(input logic [dtdiff_pkg::MONTH_W-1:0] m,
                                             input bit is_leap);
    case (m)
      4'd4, 4'd6, 4'd9, 4'd11:                    return 30;
      dtdiff_pkg::MONTH_FEB:                      return is_leap ? 29 : 28;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 31;
      default:                                    return 0;
    endcase
  endfunction

  // Day number counted from 0001-01-01 (that day is 1); returns 0 if the date is bad
  function automatic bit calendar_ordinal(input logic [dtdiff_pkg::YEAR_W-1:0] y,
                                          input logic [dtdiff_pkg::MONTH_W-1:0] m,
                                          input logic [dtdiff_pkg::DAY_W-1:0] d,
                                          output int unsigned ord);
    bit          is_leap;
    int unsigned prior;
    int unsigned len;
    ord = 0;
    if (y < dtdiff_pkg::YEAR_MIN || y > dtdiff_pkg::YEAR_MAX) return 1'b0;
    is_leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    len = month_days(m, is_leap);
    // zero length also rejects a bad month
    if (d == 0 || d > len) return 1'b0;
    prior = y - 1;
    ord = 365 * prior + prior / 4 - prior / 100 + prior / 400 + d;
    for (int k = 1; k < m; k++) ord += month_days(k[dtdiff_pkg::MONTH_W-1:0], is_leap);
    return 1'b1;
  endfunction

  function automatic date_span_t predict_span(
    input logic [dtdiff_pkg::YEAR_W-1:0]  sy,
    input logic [dtdiff_pkg::MONTH_W-1:0] sm,
    input logic [dtdiff_pkg::DAY_W-1:0]   sd,
    input logic [dtdiff_pkg::YEAR_W-1:0]  ey,
    input logic [dtdiff_pkg::MONTH_W-1:0] em,
    input logic [dtdiff_pkg::DAY_W-1:0]   ed);
    date_span_t  span;
    int unsigned start_ord;
    int unsigned end_ord;
    int unsigned diff;
    bit          start_ok;
    bit          end_ok;
    start_ok = calendar_ordinal(sy, sm, sd, start_ord);
    end_ok   = calendar_ordinal(ey, em, ed, end_ord);
    if (!start_ok || !end_ok || start_ord > end_ord) begin
      span.day_count  = '0;
      span.date_error = 1'b1;
    end else begin
      diff            = end_ord - start_ord;
      span.day_count  = diff[dtdiff_pkg::ORD_W-1:0];
      span.date_error = 1'b0;
    end
    return span;
  endfunction

  // Retire results first, then queue the prediction for a newly taken request
  always @(posedge clk) begin
    date_span_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_spans.size() == 0) begin
          $display("%0t: result with none expected: day_count %0d date_error %0b",
                   $time, out_day_count, out_date_error);
          mismatch_total++;
        end else begin
          want = expected_spans.pop_front();
          if (out_day_count !== want.day_count) begin
            $display("%0t: day_count expected %0d actual %0d",
                     $time, want.day_count, out_day_count);
            mismatch_total++;
          end
          if (out_date_error !== want.date_error) begin
            $display("%0t: date_error expected %0b actual %0b",
                     $time, want.date_error, out_date_error);
            mismatch_total++;
          end
        end
      end
      if (in_valid && in_ready)
        expected_spans.push_back(predict_span(in_start_year, in_start_month, in_start_day,
                                              in_end_year, in_end_month, in_end_day));
    end
    mismatches <= mismatch_total;
    pending    <= expected_spans.size();
  end

endmodule

@@ dv/testbench.sv @@
// Top of the date difference bench: clock, reset, request and result traffic, verdict.
`timescale 1ns / 1ps

module testbench;

  localparam int RANDOM_REQUESTS = 1700;
  localparam int STALL_LIMIT     = 2000;
  localparam int HOLD_CYCLES     = 60;
  localparam int HOLD_AT_RESULT  = 200;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [dtdiff_pkg::YEAR_W-1:0]  in_start_year = '0;
  logic [dtdiff_pkg::MONTH_W-1:0] in_start_month = '0;
  logic [dtdiff_pkg::DAY_W-1:0]   in_start_day = '0;
  logic [dtdiff_pkg::YEAR_W-1:0]  in_end_year = '0;
  logic [dtdiff_pkg::MONTH_W-1:0] in_end_month = '0;
  logic [dtdiff_pkg::DAY_W-1:0]   in_end_day = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [dtdiff_pkg::ORD_W-1:0]   out_day_count;
  logic                           out_date_error;

  int mismatches;
  int pending;
  int quiet_cycles = 0;
  bit no_idle = 1'b0;

  always #10 clk = ~clk;

  date_difference_days_core uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_start_year (in_start_year),
    .in_start_month(in_start_month),
    .in_start_day  (in_start_day),
    .in_end_year   (in_end_year),
    .in_end_month  (in_end_month),
    .in_end_day    (in_end_day),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_day_count (out_day_count),
    .out_date_error(out_date_error)
  );

  day_count_checker span_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_start_year (in_start_year),
    .in_start_month(in_start_month),
    .in_start_day  (in_start_day),
    .in_end_year   (in_end_year),
    .in_end_month  (in_end_month),
    .in_end_day    (in_end_day),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_day_count (out_day_count),
    .out_date_error(out_date_error),
    .mismatches    (mismatches),
    .pending       (pending)
  );

  // Offer one date pair after a random gap; returns right after the edge that takes it
  task automatic send_dates(input int sy, input int sm, input int sd,
                            input int ey, input int em, input int ed);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_start_year  <= sy[dtdiff_pkg::YEAR_W-1:0];
    in_start_month <= sm[dtdiff_pkg::MONTH_W-1:0];
    in_start_day   <= sd[dtdiff_pkg::DAY_W-1:0];
    in_end_year    <= ey[dtdiff_pkg::YEAR_W-1:0];
    in_end_month   <= em[dtdiff_pkg::MONTH_W-1:0];
    in_end_day     <= ed[dtdiff_pkg::DAY_W-1:0];
    in_valid       <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // Mostly plausible dates; days past 28 sometimes land past the month end
  task automatic pick_date(output int y, output int m, output int d);
    y = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 9999) : $urandom_range(1890, 2110);
    m = $urandom_range(1, 12);
    d = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 28) : $urandom_range(28, 31);
  endtask

  // Request side: directed corners, then mixed random traffic
  initial begin : request_source
    int sy, sm, sd, ey, em, ed, kind;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_dates(1, 1, 1, 1, 1, 1);            // equal dates
    send_dates(1, 1, 1, 9999, 12, 31);       // full range
    send_dates(9999, 12, 31, 1, 1, 1);       // start after end
    send_dates(2000, 2, 29, 2000, 3, 1);     // leap century
    send_dates(1900, 2, 29, 1900, 3, 1);     // Feb 29 in a common century
    send_dates(2004, 2, 29, 2005, 2, 28);
    send_dates(2023, 1, 1, 2023, 2, 29);     // Feb 29 in a common year
    send_dates(2024, 2, 30, 2024, 3, 1);     // Feb 30
    send_dates(2024, 4, 31, 2024, 5, 1);     // day past a 30-day month
    send_dates(2024, 1, 31, 2024, 12, 31);
    send_dates(2024, 0, 5, 2024, 6, 5);      // month zero
    send_dates(2024, 1, 5, 2024, 13, 5);     // month past December
    send_dates(2024, 15, 5, 2025, 1, 5);
    send_dates(2024, 1, 5, 2024, 1, 0);      // day zero
    send_dates(0, 6, 15, 2024, 6, 15);       // year zero
    send_dates(2024, 6, 15, 10000, 1, 1);    // year past the top
    send_dates(16383, 15, 31, 16383, 15, 31);
    send_dates(2024, 5, 20, 2024, 5, 10);    // later day, same month
    send_dates(1600, 12, 31, 1601, 1, 1);
    send_dates(2100, 2, 28, 2100, 3, 1);     // common century
    send_dates(9999, 1, 1, 9999, 12, 31);
    send_dates(9999, 1, 1, 9998, 12, 31);
    send_dates(1, 1, 1, 1, 1, 2);

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      // every third block of 150 runs without gaps or stalls
      no_idle = ((i / 150) % 3 == 2);
      kind = $urandom_range(0, 9);
      if (kind >= 8) begin
        // raw noise over every field bit
        sy = $urandom_range(0, 16383); sm = $urandom_range(0, 15); sd = $urandom_range(0, 31);
        ey = $urandom_range(0, 16383); em = $urandom_range(0, 15); ed = $urandom_range(0, 31);
      end else begin
        pick_date(sy, sm, sd);
        pick_date(ey, em, ed);
        if (kind == 6) begin
          // short spans inside one month
          ey = sy;
          em = sm;
        end
        // order the pair except for the deliberately unordered kind
        if (kind != 7 &&
            {sy[dtdiff_pkg::YEAR_W-1:0], sm[dtdiff_pkg::MONTH_W-1:0],
             sd[dtdiff_pkg::DAY_W-1:0]} >
            {ey[dtdiff_pkg::YEAR_W-1:0], em[dtdiff_pkg::MONTH_W-1:0],
             ed[dtdiff_pkg::DAY_W-1:0]}) begin
          {sy, ey} = {ey, sy};
          {sm, em} = {em, sm};
          {sd, ed} = {ed, sd};
        end
      end
      send_dates(sy, sm, sd, ey, em, ed);
    end
    in_valid <= 1'b0;

    // let the checker see the last request so it is counted as pending
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Result side: random stalls, plus one long hold so the block backs up
  initial begin : result_sink
    int stall;
    int results_seen;
    results_seen = 0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 4);
      if (results_seen == HOLD_AT_RESULT) stall = HOLD_CYCLES;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      results_seen++;
    end
  end

  // Watchdog on cycles with no traffic on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule

@@ files.f @@
rtl/core/dtdiff_pkg.sv
rtl/core/dtdiff_ordinal.sv
rtl/core/date_difference_days_core.sv
dv/day_count_checker.sv
dv/testbench.sv
